// ===== rtl/core/swm_pkg.sv =====
// shared types and constants of the sliding window median filter
package swm_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW = 7;
  localparam int unsigned WinLenReset = 5;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [CfgW-1:0] win_len_t;

  // per-cell compare results seen by the neighbors
  typedef struct packed {
    logic gt;  // cell lies after the new sample in the row
    logic rm;  // the leaving sample sits at or before this cell
  } swm_flag_t;

  // values broadcast to every cell of the row
  typedef struct packed {
    data_t sample;
    data_t old_val;
    logic  load;
    logic  full;
  } swm_bcast_t;

endpackage

// ===== rtl/core/swm_if.sv =====
// request channels of the sliding window median filter

interface swm_in_if;
  import swm_pkg::*;
  logic  valid;
  logic  ready;
  data_t sample;
  logic  last_in_series;
  modport source (output valid, output sample, output last_in_series, input ready);
  modport sink (input valid, input sample, input last_in_series, output ready);
endinterface

interface swm_out_if;
  import swm_pkg::*;
  logic  valid;
  logic  ready;
  data_t median;
  logic  series_end;
  modport source (output valid, output median, output series_end, input ready);
  modport sink (input valid, input median, input series_end, output ready);
endinterface

interface swm_cfg_if;
  import swm_pkg::*;
  logic     valid;
  logic     ready;
  win_len_t window_len;
  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

// ===== rtl/core/sliding_window_median.sv =====
// sliding window median filter: sorted row of cells plus median output stage
//
//   channel | dir | payload                    | request taken when
//   in_ch   | in  | sample, last_in_series     | valid && ready
//   out_ch  | out | median, series_end         | valid && ready
//   cfg_ch  | in  | window_len                 | valid && ready (always ready)
//
// one sample per cycle while the output is not stalled; the median leaves through
// the cell row and then the output register. each sample inserts into and removes
// from the sorted cell row in one update; the median is then read from the row into the output register.
// reset and a window_len write empty the window; no clearing pass is needed.
// a stalled output holds the middle stage, and the input then stalls too.
module sliding_window_median
  import swm_pkg::*;
#(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  swm_in_if.sink    in_ch,
  swm_out_if.source out_ch,
  swm_cfg_if.sink   cfg_ch
);

  localparam int unsigned IdxW = $clog2(MAX_WINDOW);
  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned ResetLen = (WinLenReset > MAX_WINDOW) ? MAX_WINDOW : WinLenReset;

  logic [CntW-1:0] win_q, win_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            pend_q, pend_last_q;
  logic            out_valid_q, out_last_q;
  data_t           median_q;

  logic            in_acc, cfg_acc, advance, full, emit;
  logic [IdxW-1:0] age_last, hi_idx, lo_idx;
  logic [CmpW-1:0] cfg_ext;
  swm_bcast_t      bcast;
  data_t           old_val;

  data_t           cell_val [MAX_WINDOW];
  logic [IdxW-1:0] cell_age [MAX_WINDOW];
  swm_flag_t       cell_flag [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] cell_old;
  logic [MAX_WINDOW-1:0] cell_valid;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign advance = pend_q && (!out_valid_q || out_ch.ready);
  assign in_ch.ready = !pend_q || advance;
  assign in_acc = in_ch.valid && in_ch.ready;

  // window length limited to 1..MAX_WINDOW
  always_comb begin
    cfg_ext = CmpW'(cfg_ch.window_len);
    win_d = win_q;
    if (cfg_acc) begin
      if (cfg_ext == '0) begin
        win_d = CntW'(1);
      end else if (cfg_ext > CmpW'(MAX_WINDOW)) begin
        win_d = CntW'(MAX_WINDOW);
      end else begin
        win_d = CntW'(cfg_ext);
      end
    end
  end

  // oldest age and middle positions for the current length
  assign age_last = IdxW'(win_q - CntW'(1));
  assign hi_idx   = IdxW'(win_q >> 1);
  assign lo_idx   = win_q[0] ? hi_idx : hi_idx - IdxW'(1);

  assign full = (fill_q == win_q);
  assign emit = in_acc && ((fill_q + CntW'(1)) >= win_q);

  // fill count of the window
  always_comb begin
    fill_d = fill_q;
    if (cfg_acc) begin
      fill_d = '0;
    end else if (in_acc) begin
      if (in_ch.last_in_series) begin
        fill_d = '0;
      end else if (!full) begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  // value of the leaving sample, picked from the one oldest cell
  always_comb begin
    old_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (cell_old[i]) begin
        old_val = old_val | cell_val[i];
      end
    end
  end

  always_comb begin
    bcast.sample  = in_ch.sample;
    bcast.old_val = old_val;
    bcast.load    = in_acc;
    bcast.full    = full;
  end

  // sorted cell row
  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    data_t           l_val, r_val;
    logic [IdxW-1:0] l_age, r_age;
    swm_flag_t       l_flag, r_flag;

    assign cell_valid[g] = (CntW'(g) < fill_q);

    if (g == 0) begin : g_first
      assign l_val  = '0;
      assign l_age  = '0;
      assign l_flag = '{gt: 1'b0, rm: 1'b0};
    end else begin : g_mid
      assign l_val  = cell_val[g-1];
      assign l_age  = cell_age[g-1];
      assign l_flag = cell_flag[g-1];
    end

    if (g == MAX_WINDOW - 1) begin : g_last
      assign r_val  = '0;
      assign r_age  = '0;
      assign r_flag = '{gt: 1'b1, rm: 1'b1};
    end else begin : g_inner
      assign r_val  = cell_val[g+1];
      assign r_age  = cell_age[g+1];
      assign r_flag = cell_flag[g+1];
    end

    swm_cell #(
      .AgeW (IdxW)
    ) u_cell (
      .clk_i        (clk_i),
      .valid_i      (cell_valid[g]),
      .bcast_i      (bcast),
      .age_last_i   (age_last),
      .left_val_i   (l_val),
      .left_age_i   (l_age),
      .left_flag_i  (l_flag),
      .right_val_i  (r_val),
      .right_age_i  (r_age),
      .right_flag_i (r_flag),
      .val_o        (cell_val[g]),
      .age_o        (cell_age[g]),
      .flag_o       (cell_flag[g]),
      .old_o        (cell_old[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CntW'(ResetLen);
      fill_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      if (in_acc) begin
        pend_q <= emit;
      end else if (advance) begin
        pend_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // median of the updated row: mean of the two middle cells, floor
  always_ff @(posedge clk_i) begin
    logic signed [DataW:0] sum;
    sum = {cell_val[lo_idx][DataW-1], cell_val[lo_idx]}
        + {cell_val[hi_idx][DataW-1], cell_val[hi_idx]};
    if (in_acc) begin
      pend_last_q <= in_ch.last_in_series;
    end
    if (advance) begin
      median_q   <= sum[DataW:1];
      out_last_q <= pend_last_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.median     = median_q;
  assign out_ch.series_end = out_last_q;

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= win_q)
    else $error("fill count beyond window length");

  assert property (@(posedge clk_i) disable iff (!rst_ni) full |-> $onehot(cell_old))
    else $error("full window without exactly one oldest cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_acc |=> fill_q == '0)
    else $error("window not emptied by length write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q && !advance) |=> pend_q && $stable(pend_last_q))
    else $error("pending result lost while output stalled");

endmodule

// ===== rtl/core/swm_cell.sv =====
// one cell of the sorted row: holds a sample and its age
module swm_cell
  import swm_pkg::*;
#(
  parameter int unsigned AgeW = 6
) (
  input  logic            clk_i,
  input  logic            valid_i,
  input  swm_bcast_t      bcast_i,
  input  logic [AgeW-1:0] age_last_i,
  input  data_t           left_val_i,
  input  logic [AgeW-1:0] left_age_i,
  input  swm_flag_t       left_flag_i,
  input  data_t           right_val_i,
  input  logic [AgeW-1:0] right_age_i,
  input  swm_flag_t       right_flag_i,
  output data_t           val_o,
  output logic [AgeW-1:0] age_o,
  output swm_flag_t       flag_o,
  output logic            old_o
);

  data_t           val_q, val_d;
  logic [AgeW-1:0] age_q, age_d;
  swm_flag_t       flag;

  // local compares against the broadcast values; empty cells sort last
  always_comb begin
    flag.gt = !valid_i || (val_q > bcast_i.sample);
    flag.rm = bcast_i.full && (!valid_i || !(val_q < bcast_i.old_val));
  end

  // oldest sample of the window; only taken while the window is full
  assign old_o = valid_i && (age_q == age_last_i);

  // remove the leaving sample, then insert the new one
  always_comb begin
    data_t           lv, sv;
    logic [AgeW-1:0] la, sa;
    logic            lg, sg;
    lv = left_flag_i.rm ? val_q : left_val_i;
    la = left_flag_i.rm ? age_q : left_age_i;
    lg = left_flag_i.rm ? flag.gt : left_flag_i.gt;
    sv = flag.rm ? right_val_i : val_q;
    sa = flag.rm ? right_age_i : age_q;
    sg = flag.rm ? right_flag_i.gt : flag.gt;
    val_d = val_q;
    age_d = age_q;
    if (bcast_i.load) begin
      if (lg) begin
        val_d = lv;
        age_d = la + AgeW'(1);
      end else if (sg) begin
        val_d = bcast_i.sample;
        age_d = '0;
      end else begin
        val_d = sv;
        age_d = sa + AgeW'(1);
      end
    end
  end

  // sample storage
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    age_q <= age_d;
  end

  assign val_o  = val_q;
  assign age_o  = age_q;
  assign flag_o = flag;

endmodule
